// ===== rtl/ssi_enc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SSI encoder reader package
// Shared types and constants for the SSI absolute encoder reader.
// ----------------------------------------------------------------------------
package ssi_enc_pkg;

	localparam int POS_W      = 16;
	localparam int FLAG_W     = 4;
	localparam int DBITS_W    = 5;
	localparam int TIMING_W   = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int BCNT_W     = 5;

	localparam logic [DBITS_W-1:0] MIN_DATA_BITS = 5'd10;
	localparam logic [DBITS_W-1:0] TRAILER_BITS  = 5'd4;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_DATA_BITS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SETUP       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET      = 2'd3;

	typedef struct packed {
		logic [DBITS_W-1:0]  data_bits;
		logic [TIMING_W-1:0] half_period_ticks;
		logic [TIMING_W-1:0] select_setup_ticks;
	} timing_cfg_t;

	typedef struct packed {
		logic              clock_out;
		logic              frame_n_out;
		logic              select_out;
		logic              busy;
		logic              frame_done;
		logic              reading_valid;
		logic [POS_W-1:0]  position;
		logic [FLAG_W-1:0] flags;
	} seq_result_t;

endpackage
`default_nettype wire

// ===== rtl/ssi_enc_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SSI encoder frame sequencer
// Steps the select/frame/clock sequence one tick per request, shifts in the
// frame, checks parity and holds the last good reading.
// ----------------------------------------------------------------------------
module ssi_enc_seq #(
	parameter int MAX_DATA_BITS = 16,
	parameter int TICK_WIDTH    = 8
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        step,
	input  wire                        start_read,
	input  wire                        data_in,
	input  wire ssi_enc_pkg::timing_cfg_t cfg,
	output ssi_enc_pkg::seq_result_t   res
);

	localparam int SHIFT_W = MAX_DATA_BITS + 4;
	localparam int EXT_W   = (TICK_WIDTH > ssi_enc_pkg::TIMING_W) ?
	                         TICK_WIDTH : ssi_enc_pkg::TIMING_W;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SETUP,
		PH_LOW,
		PH_HIGH
	} phase_t;

	phase_t                           phase_q, n_phase;
	logic [TICK_WIDTH-1:0]            tick_q, n_tick;
	logic [ssi_enc_pkg::BCNT_W-1:0]   bit_q, n_bit;
	logic [SHIFT_W-1:0]               shift_q, n_shift;
	logic                             odd_q, n_odd;
	logic [ssi_enc_pkg::POS_W-1:0]    pos_q, n_pos;
	logic [ssi_enc_pkg::FLAG_W-1:0]   flags_q, n_flags;
	logic                             valid_q, n_valid;
	logic                             select_q, n_select;
	logic                             clk_q, n_clk;
	logic                             frame_q, n_frame;
	logic                             done, fall;

	logic [EXT_W-1:0]                 hp_ext, setup_ext;
	logic [TICK_WIDTH-1:0]            hp, setup;
	logic [ssi_enc_pkg::DBITS_W-1:0]  dbits, flen;

	// timing registers: low TICK_WIDTH bits only, zero acts as one
	always_comb begin
		hp_ext    = EXT_W'(cfg.half_period_ticks);
		setup_ext = EXT_W'(cfg.select_setup_ticks);
		hp        = hp_ext[TICK_WIDTH-1:0];
		setup     = setup_ext[TICK_WIDTH-1:0];
		if (hp == '0) begin
			hp = TICK_WIDTH'(1);
		end
		if (setup == '0) begin
			setup = TICK_WIDTH'(1);
		end
	end

	always_comb begin
		dbits = cfg.data_bits;
		if (dbits < ssi_enc_pkg::MIN_DATA_BITS) begin
			dbits = ssi_enc_pkg::MIN_DATA_BITS;
		end
		if (dbits > ssi_enc_pkg::DBITS_W'(MAX_DATA_BITS)) begin
			dbits = ssi_enc_pkg::DBITS_W'(MAX_DATA_BITS);
		end
		flen = dbits + ssi_enc_pkg::TRAILER_BITS;
	end

	always_comb begin
		n_phase  = phase_q;
		n_tick   = tick_q;
		n_bit    = bit_q;
		n_shift  = shift_q;
		n_odd    = odd_q;
		n_pos    = pos_q;
		n_flags  = flags_q;
		n_valid  = valid_q;
		n_select = select_q;
		n_clk    = clk_q;
		n_frame  = frame_q;
		done     = 1'b0;
		fall     = 1'b0;

		unique case (phase_q)
			PH_IDLE: begin
				if (start_read) begin
					n_select = 1'b1;
					n_shift  = '0;
					n_odd    = 1'b0;
					n_bit    = '0;
					n_tick   = TICK_WIDTH'(1);
					n_phase  = PH_SETUP;
				end
			end
			PH_SETUP: begin
				if (tick_q >= setup) begin
					fall = 1'b1;
				end else if (tick_q != '1) begin
					n_tick = tick_q + TICK_WIDTH'(1);
				end
			end
			PH_LOW: begin
				if (tick_q >= hp) begin
					n_clk   = 1'b1;
					n_tick  = TICK_WIDTH'(1);
					n_phase = PH_HIGH;
				end else if (tick_q != '1) begin
					n_tick = tick_q + TICK_WIDTH'(1);
				end
			end
			PH_HIGH: begin
				if (tick_q >= hp) begin
					if (bit_q >= flen) begin
						n_clk   = 1'b1;
						n_frame = 1'b1;
						n_phase = PH_IDLE;
						n_tick  = '0;
						done    = 1'b1;
						if (odd_q == shift_q[0]) begin
							n_pos   = ssi_enc_pkg::POS_W'(shift_q[SHIFT_W-1:4]);
							n_flags = shift_q[3:0];
							n_valid = 1'b1;
						end else begin
							n_valid = 1'b0;
						end
					end else begin
						fall = 1'b1;
					end
				end else if (tick_q != '1) begin
					n_tick = tick_q + TICK_WIDTH'(1);
				end
			end
			default: begin
				n_phase = PH_IDLE;
			end
		endcase

		// falling serial clock edge: sample one bit, parity skips the last one
		if (fall) begin
			n_clk   = 1'b0;
			n_frame = 1'b0;
			if (data_in && (({1'b0, bit_q} + 6'd1) < {1'b0, flen})) begin
				n_odd = ~odd_q;
			end
			n_shift = {shift_q[SHIFT_W-2:0], data_in};
			if (bit_q != '1) begin
				n_bit = bit_q + ssi_enc_pkg::BCNT_W'(1);
			end
			n_tick  = TICK_WIDTH'(1);
			n_phase = PH_LOW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			tick_q   <= '0;
			bit_q    <= '0;
			shift_q  <= '0;
			odd_q    <= 1'b0;
			pos_q    <= '0;
			flags_q  <= '0;
			valid_q  <= 1'b0;
			select_q <= 1'b0;
			clk_q    <= 1'b1;
			frame_q  <= 1'b1;
		end else if (step) begin
			phase_q  <= n_phase;
			tick_q   <= n_tick;
			bit_q    <= n_bit;
			shift_q  <= n_shift;
			odd_q    <= n_odd;
			pos_q    <= n_pos;
			flags_q  <= n_flags;
			valid_q  <= n_valid;
			select_q <= n_select;
			clk_q    <= n_clk;
			frame_q  <= n_frame;
		end
	end

	always_comb begin
		res.clock_out     = n_clk;
		res.frame_n_out   = n_frame;
		res.select_out    = n_select;
		res.busy          = (n_phase != PH_IDLE);
		res.frame_done    = done;
		res.reading_valid = n_valid;
		res.position      = n_pos;
		res.flags         = n_flags;
	end

endmodule
`default_nettype wire

// ===== rtl/ssi_absolute_encoder_reader.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SSI absolute encoder reader
// SSI master for an absolute rotary encoder with parity check and offset.
// ----------------------------------------------------------------------------
// Usage:
//   Each input request is one sequencer tick carrying start_read and the
//   sampled encoder data pin. Every request yields exactly one result with
//   the pin levels (clock, frame, select), busy, a frame_done pulse and the
//   held reading of the last frame that passed parity.
//   A frame takes setup + 2 * half_period * (data_bits + 4) + 1 ticks: the
//   start tick precedes the setup ticks and the last high tick ends the frame.
//   The result of a request appears in the output register at the edge
//   that takes the request. One request is taken every cycle while
//   in_stall is low.
//   When the receiver stalls, the output register holds its result and
//   in_stall rises, so no tick is taken until the result is delivered.
//   Reset sets the sequencer clock and frame levels high, select low, clears
//   its held reading and loads the default configuration. The user writes
//   configuration via cfg_we/cfg_index/cfg_data while idle; not enforced.
// ----------------------------------------------------------------------------
module ssi_absolute_encoder_reader #(
	parameter int MAX_DATA_BITS = 16,
	parameter int TICK_WIDTH    = 8
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire [ssi_enc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [ssi_enc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire                                 start_read,
	input  wire                                 data_in,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output logic                                clock_out,
	output logic                                frame_n_out,
	output logic                                select_out,
	output logic                                busy_res,
	output logic                                frame_done,
	output logic                                reading_valid,
	output logic [ssi_enc_pkg::POS_W-1:0]       position,
	output logic [ssi_enc_pkg::POS_W-1:0]       position_with_offset,
	output logic                                mag_high_flag,
	output logic                                mag_low_flag,
	output logic                                ready_flag,
	output logic                                parity_bit
);

	ssi_enc_pkg::timing_cfg_t      cfg_q;
	logic [ssi_enc_pkg::POS_W-1:0] offset_q;
	ssi_enc_pkg::seq_result_t      res;
	ssi_enc_pkg::seq_result_t      res_s1;
	logic [ssi_enc_pkg::POS_W-1:0] pos_off_s1;
	logic                          valid_s1;
	logic                          step;

	assign in_stall = valid_s1 && out_stall;
	assign step     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.data_bits          <= 5'd16;
			cfg_q.half_period_ticks  <= 8'd4;
			cfg_q.select_setup_ticks <= 8'd8;
			offset_q                 <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ssi_enc_pkg::REG_DATA_BITS:
					cfg_q.data_bits <= cfg_data[ssi_enc_pkg::DBITS_W-1:0];
				ssi_enc_pkg::REG_HALF_PERIOD:
					cfg_q.half_period_ticks <= cfg_data[ssi_enc_pkg::TIMING_W-1:0];
				ssi_enc_pkg::REG_SETUP:
					cfg_q.select_setup_ticks <= cfg_data[ssi_enc_pkg::TIMING_W-1:0];
				ssi_enc_pkg::REG_OFFSET:
					offset_q <= cfg_data[ssi_enc_pkg::POS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	ssi_enc_seq #(
		.MAX_DATA_BITS(MAX_DATA_BITS),
		.TICK_WIDTH   (TICK_WIDTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.start_read(start_read),
		.data_in   (data_in),
		.cfg       (cfg_q),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (step) begin
			valid_s1 <= 1'b1;
		end else if (!out_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s1     <= res;
			pos_off_s1 <= res.position + offset_q;
		end
	end

	assign out_valid            = valid_s1;
	assign clock_out            = res_s1.clock_out;
	assign frame_n_out          = res_s1.frame_n_out;
	assign select_out           = res_s1.select_out;
	assign busy_res             = res_s1.busy;
	assign frame_done           = res_s1.frame_done;
	assign reading_valid        = res_s1.reading_valid;
	assign position             = res_s1.position;
	assign position_with_offset = pos_off_s1;
	assign mag_high_flag        = res_s1.flags[3];
	assign mag_low_flag         = res_s1.flags[2];
	assign ready_flag           = res_s1.flags[1];
	assign parity_bit           = res_s1.flags[0];

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SSI absolute encoder reader testbench
// Drives sequencer ticks through the request channel with random idling on
// both sides, mirrors the sequencer, parity check and held reading in a
// scoreboard class, and checks every result field by field. Frames are
// mostly well-formed with random content; the rest are bad-parity or noise.
// ----------------------------------------------------------------------------

typedef enum logic [1:0] {SEQ_IDLE, SEQ_SETUP, SEQ_CLK_LOW, SEQ_CLK_HIGH} seq_phase_t;

typedef struct packed {
	logic        clock_out;
	logic        frame_n_out;
	logic        select_out;
	logic        busy;
	logic        frame_done;
	logic        reading_valid;
	logic [15:0] position;
	logic [15:0] position_with_offset;
	logic        magnet_high;
	logic        magnet_low;
	logic        ready;
	logic        parity;
} pin_state_t;

class ssi_reader_mirror;
	logic [4:0]  data_bits;
	logic [7:0]  half_ticks;
	logic [7:0]  setup_ticks;
	logic [15:0] offset;
	seq_phase_t  phase;
	logic [7:0]  tick_cnt;
	logic [4:0]  bit_cnt;
	logic [19:0] shreg;
	logic        ones_odd;
	logic [15:0] held_pos;
	logic [3:0]  held_flags;
	logic        valid_flag;
	logic        select_lvl;
	logic        clk_lvl;
	logic        frame_lvl;
	pin_state_t  pin_levels_q[$];
	int          n_errors;

	function new();
		data_bits   = 5'd16;
		half_ticks  = 8'd4;
		setup_ticks = 8'd8;
		offset      = 16'd0;
		phase       = SEQ_IDLE;
		tick_cnt    = 8'd0;
		bit_cnt     = 5'd0;
		shreg       = 20'd0;
		ones_odd    = 1'b0;
		held_pos    = 16'd0;
		held_flags  = 4'd0;
		valid_flag  = 1'b0;
		select_lvl  = 1'b0;
		clk_lvl     = 1'b1;
		frame_lvl   = 1'b1;
		n_errors    = 0;
	endfunction

	function int frame_len();
		int d;
		d = data_bits;
		if (d < 10) d = 10;
		if (d > 16) d = 16;
		return d + 4;
	endfunction

	function logic [7:0] at_least_one(logic [7:0] v);
		return (v == 8'd0) ? 8'd1 : v;
	endfunction

	function void set_reg(logic [ssi_enc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
		case (idx)
			ssi_enc_pkg::REG_DATA_BITS:   data_bits   = val[4:0];
			ssi_enc_pkg::REG_HALF_PERIOD: half_ticks  = val[7:0];
			ssi_enc_pkg::REG_SETUP:       setup_ticks = val[7:0];
			default:                      offset      = val;
		endcase
	endfunction

	// falling serial clock: sample one bit; the parity bit itself is not counted
	function void sample_bit(logic din);
		clk_lvl   = 1'b0;
		frame_lvl = 1'b0;
		if (din && (int'(bit_cnt) + 1 < frame_len())) ones_odd ^= 1'b1;
		shreg = {shreg[18:0], din};
		if (bit_cnt != 5'd31) bit_cnt++;
		tick_cnt = 8'd1;
		phase    = SEQ_CLK_LOW;
	endfunction

	function void count_tick();
		if (tick_cnt != 8'hFF) tick_cnt++;
	endfunction

	function void note_tick(logic start, logic din);
		logic        done;
		logic [7:0]  hp;
		logic [15:0] pos_sum;
		pin_state_t  want;
		done = 1'b0;
		hp   = at_least_one(half_ticks);
		case (phase)
			SEQ_IDLE: begin
				if (start) begin
					select_lvl = 1'b1;
					shreg      = 20'd0;
					ones_odd   = 1'b0;
					bit_cnt    = 5'd0;
					tick_cnt   = 8'd1;
					phase      = SEQ_SETUP;
				end
			end
			SEQ_SETUP: begin
				if (tick_cnt >= at_least_one(setup_ticks)) sample_bit(din);
				else count_tick();
			end
			SEQ_CLK_LOW: begin
				if (tick_cnt >= hp) begin
					clk_lvl  = 1'b1;
					tick_cnt = 8'd1;
					phase    = SEQ_CLK_HIGH;
				end else begin
					count_tick();
				end
			end
			default: begin
				if (tick_cnt < hp) begin
					count_tick();
				end else if (int'(bit_cnt) >= frame_len()) begin
					clk_lvl   = 1'b1;
					frame_lvl = 1'b1;
					phase     = SEQ_IDLE;
					tick_cnt  = 8'd0;
					done      = 1'b1;
					if (ones_odd == shreg[0]) begin
						held_pos   = shreg[19:4];
						held_flags = shreg[3:0];
						valid_flag = 1'b1;
					end else begin
						valid_flag = 1'b0;
					end
				end else begin
					sample_bit(din);
				end
			end
		endcase
		pos_sum = held_pos + offset;
		want = '{clk_lvl, frame_lvl, select_lvl, phase != SEQ_IDLE, done, valid_flag,
			held_pos, pos_sum, held_flags[3], held_flags[2], held_flags[1], held_flags[0]};
		pin_levels_q.push_back(want);
	endfunction

	function int pending();
		return pin_levels_q.size();
	endfunction

	function void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			n_errors++;
		end
	endfunction

	function void check_result(pin_state_t got);
		pin_state_t want;
		if (pin_levels_q.size() == 0) begin
			$error("result with no request outstanding");
			n_errors++;
			return;
		end
		want = pin_levels_q.pop_front();
		check_field("clock_out", 16'(want.clock_out), 16'(got.clock_out));
		check_field("frame_n_out", 16'(want.frame_n_out), 16'(got.frame_n_out));
		check_field("select_out", 16'(want.select_out), 16'(got.select_out));
		check_field("busy_res", 16'(want.busy), 16'(got.busy));
		check_field("frame_done", 16'(want.frame_done), 16'(got.frame_done));
		check_field("reading_valid", 16'(want.reading_valid), 16'(got.reading_valid));
		check_field("position", want.position, got.position);
		check_field("position_with_offset", want.position_with_offset,
			got.position_with_offset);
		check_field("mag_high_flag", 16'(want.magnet_high), 16'(got.magnet_high));
		check_field("mag_low_flag", 16'(want.magnet_low), 16'(got.magnet_low));
		check_field("ready_flag", 16'(want.ready), 16'(got.ready));
		check_field("parity_bit", 16'(want.parity), 16'(got.parity));
	endfunction
endclass

module testbench;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        cfg_we     = 1'b0;
	logic [ssi_enc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [ssi_enc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
	logic        in_valid   = 1'b0;
	logic        start_read = 1'b0;
	logic        data_in    = 1'b0;
	logic        out_stall  = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic        clock_out;
	logic        frame_n_out;
	logic        select_out;
	logic        busy_res;
	logic        frame_done;
	logic        reading_valid;
	logic [15:0] position;
	logic [15:0] position_with_offset;
	logic        mag_high_flag;
	logic        mag_low_flag;
	logic        ready_flag;
	logic        parity_bit;

	ssi_reader_mirror mirror;
	bit quiet = 1'b0;
	int n_ticks = 0;

	ssi_absolute_encoder_reader i_dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_we               (cfg_we),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data),
		.in_valid             (in_valid),
		.in_stall             (in_stall),
		.start_read           (start_read),
		.data_in              (data_in),
		.out_valid            (out_valid),
		.out_stall            (out_stall),
		.clock_out            (clock_out),
		.frame_n_out          (frame_n_out),
		.select_out           (select_out),
		.busy_res             (busy_res),
		.frame_done           (frame_done),
		.reading_valid        (reading_valid),
		.position             (position),
		.position_with_offset (position_with_offset),
		.mag_high_flag        (mag_high_flag),
		.mag_low_flag         (mag_low_flag),
		.ready_flag           (ready_flag),
		.parity_bit           (parity_bit)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#15000000;
		$display("testbench failed");
		$finish;
	end

	// result side: random stall bursts, check every delivered result
	initial begin : result_side
		int stall_left;
		pin_state_t got;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				got = '{clock_out, frame_n_out, select_out, busy_res, frame_done,
					reading_valid, position, position_with_offset, mag_high_flag,
					mag_low_flag, ready_flag, parity_bit};
				mirror.check_result(got);
			end
			if (!quiet && stall_left == 0 && $urandom_range(0, 11) == 0)
				stall_left = $urandom_range(1, 13);
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_tick(input logic start, input logic din);
		if (!quiet && $urandom_range(0, 24) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		start_read <= start;
		data_in    <= din;
		do @(posedge clk); while (in_stall);
		mirror.note_tick(start, din);
		n_ticks++;
	endtask

	// hold off requests until every outstanding result is back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (mirror.pending() != 0);
	endtask

	task automatic put_reg(input logic [ssi_enc_pkg::CFG_IDX_W-1:0] idx,
			input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		mirror.set_reg(idx, val);
	endtask

	task automatic write_cfg(input logic [4:0] db, input logic [7:0] hp,
			input logic [7:0] su, input logic [15:0] off);
		put_reg(ssi_enc_pkg::REG_DATA_BITS, {11'd0, db});
		put_reg(ssi_enc_pkg::REG_HALF_PERIOD, {8'd0, hp});
		put_reg(ssi_enc_pkg::REG_SETUP, {8'd0, su});
		put_reg(ssi_enc_pkg::REG_OFFSET, off);
		cfg_we <= 1'b0;
	endtask

	// frame word, MSB first: position, magnet high, magnet low, ready, parity
	function automatic logic [19:0] make_word(input int len, input logic [15:0] pos,
			input logic [2:0] flags, input bit good);
		logic [19:0] mask;
		logic [19:0] body;
		mask = (20'd1 << (len - 4)) - 20'd1;
		body = ((({4'd0, pos}) & mask) << 3) | {17'd0, flags};
		return {body[18:0], (^body) ^ !good};
	endfunction

	// tick until the frame ends or stop_bits have been sampled
	task automatic clock_frame(input logic [19:0] word, input int len, input bit noisy,
			input int start_rate, input int stop_bits);
		logic st;
		logic d;
		while (mirror.phase != SEQ_IDLE && int'(mirror.bit_cnt) < stop_bits) begin
			st = (start_rate > 0) && ($urandom_range(0, start_rate - 1) == 0);
			if (noisy || int'(mirror.bit_cnt) >= len) d = 1'($urandom_range(0, 1));
			else d = word[len - 1 - int'(mirror.bit_cnt)];
			send_tick(st, d);
		end
	endtask

	task automatic run_frame(input logic [19:0] word, input bit noisy,
			input int start_rate);
		int len;
		len = mirror.frame_len();
		send_tick(1'b1, word[len - 1]);
		clock_frame(word, len, noisy, start_rate, 32);
	endtask

	initial begin : stimulus
		int n_frames;
		int choice;
		logic [19:0] word;
		logic [15:0] pos;
		logic [4:0]  db;
		logic [7:0]  hp;
		logic [7:0]  su;
		logic [15:0] off;
		mirror = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults after reset, all-zero frame
		run_frame(20'd0, 1'b0, 0);
		repeat (3) send_tick(1'b0, 1'b1);
		drain();
		write_cfg(5'd10, 8'd1, 8'd1, 16'hFFFF);
		run_frame(make_word(14, 16'hFFFF, 3'b111, 1'b1), 1'b0, 0);
		// parity failure keeps the held reading
		run_frame(make_word(14, 16'h0155, 3'b010, 1'b0), 1'b0, 0);
		// zero timing acts as one, short width clamps to ten; start held while busy
		drain();
		write_cfg(5'd0, 8'd0, 8'd0, 16'h0000);
		run_frame(make_word(14, 16'h02AA, 3'b101, 1'b1), 1'b0, 1);
		// oversize width clamps to sixteen; offset sum wraps
		drain();
		write_cfg(5'd31, 8'd2, 8'd3, 16'h8000);
		run_frame(make_word(20, 16'hFFFF, 3'b000, 1'b1), 1'b0, 0);
		drain();
		write_cfg(5'd11, 8'd1, 8'd2, 16'h0001);
		run_frame(make_word(15, 16'($urandom), 3'b100, 1'b1), 1'b0, 0);
		drain();
		write_cfg(5'd13, 8'd3, 8'd1, 16'h7FFF);
		run_frame(make_word(17, 16'($urandom), 3'b011, 1'b1), 1'b0, 0);
		// width shrunk in the middle of a frame
		drain();
		write_cfg(5'd16, 8'd1, 8'd1, 16'h1234);
		word = make_word(20, 16'($urandom), 3'($urandom), 1'b1);
		send_tick(1'b1, word[19]);
		clock_frame(word, 20, 1'b0, 0, 9);
		drain();
		put_reg(ssi_enc_pkg::REG_DATA_BITS, 16'd10);
		cfg_we <= 1'b0;
		clock_frame(word, 20, 1'b0, 0, 32);
		// longest select setup
		drain();
		write_cfg(5'd10, 8'd1, 8'd255, 16'hFFFF);
		run_frame(make_word(14, 16'($urandom), 3'($urandom), 1'b1), 1'b0, 0);

		drain();
		n_frames = 0;
		while (n_ticks < 1400) begin
			if (n_ticks > 1150) quiet = 1'b1;
			if (n_frames >= 5) begin
				n_frames = 0;
				if ($urandom_range(0, 3) == 0) db = 5'($urandom_range(0, 31));
				else db = 5'(10 + 2 * $urandom_range(0, 3));
				if ($urandom_range(0, 9) == 0) hp = 8'($urandom_range(3, 9));
				else hp = 8'($urandom_range(0, 2));
				if ($urandom_range(0, 19) == 0) su = 8'($urandom_range(0, 255));
				else su = 8'($urandom_range(0, 4));
				off = 16'($urandom);
				drain();
				write_cfg(db, hp, su, off);
			end
			choice = $urandom_range(0, 9);
			if (choice < 7) begin
				if ($urandom_range(0, 7) == 0) pos = {16{$urandom_range(0, 1) == 1}};
				else pos = 16'($urandom);
				word = make_word(mirror.frame_len(), pos, 3'($urandom),
					$urandom_range(0, 3) != 0);
				run_frame(word, 1'b0, 8);
				n_frames++;
			end else if (choice < 9) begin
				run_frame(20'd0, 1'b1, 4);
				n_frames++;
			end else begin
				repeat ($urandom_range(1, 4)) send_tick(1'b0, 1'($urandom_range(0, 1)));
			end
		end

		in_valid <= 1'b0;
		repeat (1000) begin
			@(posedge clk);
			if (mirror.pending() == 0) break;
		end
		repeat (5) @(posedge clk);
		if (mirror.pending() != 0) begin
			$error("%0d results never arrived", mirror.pending());
			mirror.n_errors++;
		end
		if (mirror.n_errors == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
